// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define MSE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define MSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/mse_pkg.sv =====
// Shared constants, types and controller/datapath interface structs for the merge sorter.
`timescale 1ns / 1ps

package mse_pkg;

    localparam int MAX_LEN = 64;
    localparam int KEY_W   = 32;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int CNT_W   = ADDR_W + 1;

    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic [CNT_W-1:0]        t_cnt;
    typedef logic [ADDR_W-1:0]       t_addr;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // store the input key, bump the count
        logic sort_init;  // first pass: width one, source is the main buffer
        logic run_init;   // compute the bounds of the next run pair
        logic merge_wr;   // pick one head, write it to the destination
        logic run_next;   // move to the next run pair of the pass
        logic pass_next;  // double the width, swap the buffers
        logic out_init;   // rewind the output index
        logic out_rd;     // read one sorted key for output
        logic clear;      // empty the list
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic sort_done;  // run width covers the whole list
        logic run_last;   // this write finishes the run pair
        logic pass_last;  // the run pair just merged ends the list
        logic out_last;   // this read fetches the last sorted key
    } t_sts;

endpackage

// ===== hdl/merge_sort_engine.sv =====
// Top level of the merge sorter: controller plus datapath.
`timescale 1ns / 1ps

// Merge sort engine for up to 64 signed Q16.16 keys. Pulse start with a key
// while busy is low; each such beat is stored, and keys beyond 64 are
// dropped. A beat with i_last_element set raises busy and sorts the stored
// list ascending by bottom-up merge passes that alternate between two buffer
// RAMs. Each pass merges run pairs one key per write, each write waiting on
// the registered read of the buffer RAMs, and doubles the run width, over
// ceil(log2 n) passes; then the n sorted keys leave at one beat per cycle
// on o_valid, the last with o_run_end, and busy falls the cycle after.
// Results cannot be held off: take each o_valid beat as it comes.
module merge_sort_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  mse_pkg::t_key i_key_value,
    input  logic          i_last_element,
    output logic          busy,
    output logic          o_valid,
    output mse_pkg::t_key o_sorted_value,
    output logic          o_run_end
);

    import mse_pkg::*;

    t_cmd cmd;
    t_sts sts;

    mse_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_last_element (i_last_element),
        .i_sts          (sts),
        .o_cmd          (cmd),
        .o_busy         (busy)
    );

    mse_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_key_value    (i_key_value),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_valid        (o_valid),
        .o_sorted_value (o_sorted_value),
        .o_run_end      (o_run_end)
    );

endmodule

// ===== hdl/mse_ram.sv =====
// Generic simple-dual-port RAM: one write port, two registered read ports.
`timescale 1ns / 1ps

module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // Write, then register both reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== hdl/mse_ctrl.sv =====
// Controller state machine: load, merge passes and output sequencing.
`timescale 1ns / 1ps

module mse_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_last_element,
    input  mse_pkg::t_sts i_sts,
    output mse_pkg::t_cmd o_cmd,
    output logic          o_busy
);

    import mse_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_PASS_CHK  = 3'd1;
    localparam logic [2:0] S_RUN_SETUP = 3'd2;
    localparam logic [2:0] S_MERGE_RD  = 3'd3;
    localparam logic [2:0] S_MERGE_WR  = 3'd4;
    localparam logic [2:0] S_RUN_NEXT  = 3'd5;
    localparam logic [2:0] S_OUT_RD    = 3'd6;
    localparam logic [2:0] S_OUT_TAIL  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_cmd       cmd;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    if (i_last_element) begin
                        cmd.sort_init = 1'b1;
                        n_state       = S_PASS_CHK;
                    end
                end
            end
            S_PASS_CHK: begin
                if (i_sts.sort_done) begin
                    cmd.out_init = 1'b1;
                    n_state      = S_OUT_RD;
                end else begin
                    n_state = S_RUN_SETUP;
                end
            end
            S_RUN_SETUP: begin
                cmd.run_init = 1'b1;
                n_state      = S_MERGE_RD;
            end
            S_MERGE_RD: begin
                // wait for both heads out of the registered read
                n_state = S_MERGE_WR;
            end
            S_MERGE_WR: begin
                cmd.merge_wr = 1'b1;
                n_state      = i_sts.run_last ? S_RUN_NEXT : S_MERGE_RD;
            end
            S_RUN_NEXT: begin
                if (i_sts.pass_last) begin
                    cmd.pass_next = 1'b1;
                    n_state       = S_PASS_CHK;
                end else begin
                    cmd.run_next = 1'b1;
                    n_state      = S_RUN_SETUP;
                end
            end
            S_OUT_RD: begin
                cmd.out_rd = 1'b1;
                if (i_sts.out_last) begin
                    cmd.clear = 1'b1;
                    n_state   = S_OUT_TAIL;
                end
            end
            S_OUT_TAIL: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== hdl/mse_datapath.sv =====
// Datapath: two ping-pong key buffers, run bounds, head compare and output stage.
`timescale 1ns / 1ps

module mse_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mse_pkg::t_key i_key_value,
    input  mse_pkg::t_cmd i_cmd,
    output mse_pkg::t_sts o_sts,
    output logic          o_valid,
    output mse_pkg::t_key o_sorted_value,
    output logic          o_run_end
);

    import mse_pkg::*;

    localparam t_cnt MaxCnt = t_cnt'(MAX_LEN);

    t_cnt r_count;
    t_cnt r_w;
    t_cnt r_lo;
    t_cnt r_mid;
    t_cnt r_hi;
    t_cnt r_l;
    t_cnt r_r;
    t_cnt r_k;
    t_cnt r_idx;
    logic r_sel;        // 0: main is the source, 1: work is the source
    logic r_emit;
    logic r_emit_last;

    logic [CNT_W:0] sum_mid;
    logic [CNT_W:0] sum_hi;
    t_cnt           n_mid;
    t_cnt           n_hi;
    t_key           main_a;
    t_key           main_b;
    t_key           work_a;
    t_key           work_b;
    t_key           src_a;
    t_key           src_b;
    logic           take_right;
    t_key           merge_key;
    logic           load_we;
    logic           main_we;
    logic           work_we;
    t_addr          main_waddr;
    t_key           main_wdata;
    t_addr          raddr_a;
    t_addr          raddr_b;

    // Clamp the run pair bounds to the list length
    assign sum_mid = {1'b0, r_lo} + {1'b0, r_w};
    assign sum_hi  = sum_mid + {1'b0, r_w};
    assign n_mid   = (sum_mid < {1'b0, r_count}) ? sum_mid[CNT_W-1:0] : r_count;
    assign n_hi    = (sum_hi < {1'b0, r_count}) ? sum_hi[CNT_W-1:0] : r_count;

    // Pick the smaller head; the right run wins ties
    assign src_a      = r_sel ? work_a : main_a;
    assign src_b      = r_sel ? work_b : main_b;
    assign take_right = (r_r < r_hi) && ((r_l >= r_mid) || (src_b <= src_a));
    assign merge_key  = take_right ? src_b : src_a;

    // Buffer write and read ports
    assign load_we    = i_cmd.load && (r_count < MaxCnt);
    assign main_we    = load_we || (i_cmd.merge_wr && r_sel);
    assign work_we    = i_cmd.merge_wr && !r_sel;
    assign main_waddr = i_cmd.load ? r_count[ADDR_W-1:0] : r_k[ADDR_W-1:0];
    assign main_wdata = i_cmd.load ? i_key_value : merge_key;
    assign raddr_a    = i_cmd.out_rd ? r_idx[ADDR_W-1:0] : r_l[ADDR_W-1:0];
    assign raddr_b    = r_r[ADDR_W-1:0];

    mse_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_LEN)
    ) u_main_ram (
        .i_clk     (i_clk),
        .i_we      (main_we),
        .i_waddr   (main_waddr),
        .i_wdata   (main_wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (main_a),
        .o_rdata_b (main_b)
    );

    mse_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_LEN)
    ) u_work_ram (
        .i_clk     (i_clk),
        .i_we      (work_we),
        .i_waddr   (r_k[ADDR_W-1:0]),
        .i_wdata   (merge_key),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (work_a),
        .o_rdata_b (work_b)
    );

    // Element count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
        end else if (load_we) begin
            r_count <= r_count + t_cnt'(1);
        end
    end

    // Pass and run bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.sort_init) begin
            r_w   <= t_cnt'(1);
            r_lo  <= '0;
            r_sel <= 1'b0;
        end else if (i_cmd.pass_next) begin
            r_w   <= {r_w[CNT_W-2:0], 1'b0};
            r_lo  <= '0;
            r_sel <= !r_sel;
        end else if (i_cmd.run_next) begin
            r_lo <= r_hi;
        end

        if (i_cmd.run_init) begin
            r_mid <= n_mid;
            r_hi  <= n_hi;
            r_l   <= r_lo;
            r_r   <= n_mid;
            r_k   <= r_lo;
        end else if (i_cmd.merge_wr) begin
            r_k <= r_k + t_cnt'(1);
            if (take_right) begin
                r_r <= r_r + t_cnt'(1);
            end else begin
                r_l <= r_l + t_cnt'(1);
            end
        end

        if (i_cmd.out_init) begin
            r_idx <= '0;
        end else if (i_cmd.out_rd) begin
            r_idx <= r_idx + t_cnt'(1);
        end
    end

    // Output beat comes in the cycle after its read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit      <= 1'b0;
            r_emit_last <= 1'b0;
        end else begin
            r_emit      <= i_cmd.out_rd;
            r_emit_last <= i_cmd.out_rd && o_sts.out_last;
        end
    end

    assign o_sts.sort_done = (r_w >= r_count);
    assign o_sts.run_last  = (({1'b0, r_k} + {{CNT_W{1'b0}}, 1'b1}) == {1'b0, r_hi});
    assign o_sts.pass_last = (r_hi == r_count);
    assign o_sts.out_last  = (({1'b0, r_idx} + {{CNT_W{1'b0}}, 1'b1}) == {1'b0, r_count});

    assign o_valid        = r_emit;
    assign o_sorted_value = src_a;
    assign o_run_end      = r_emit_last;

endmodule

// ===== hdl/mse_checker.sv =====
// Port-level checker for the merge sorter, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mse_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_last_element,
    input logic o_valid,
    input logic o_run_end
);

    // Run end only on a valid beat
    `MSE_ASSERT_SAME(a_end_on_beat, i_clk, i_rst_n, o_run_end, o_valid, "run_end without valid")

    // Results only while sorting
    `MSE_ASSERT_SAME(a_beat_busy, i_clk, i_rst_n, o_valid, busy, "result beat while idle")

    // A plain load beat leaves the block idle
    `MSE_ASSERT_NEXT(a_load_idle, i_clk, i_rst_n, start && !busy && !i_last_element, !busy,
        "busy after a non-final load")

    // The final key starts the sort
    `MSE_ASSERT_NEXT(a_last_busy, i_clk, i_rst_n, start && !busy && i_last_element, busy,
        "no sort after the final key")

    // The block frees up right after the run ends
    `MSE_ASSERT_NEXT(a_end_idle, i_clk, i_rst_n, o_run_end, !busy && !o_valid,
        "still busy after the run end")

endmodule

bind merge_sort_engine mse_checker u_mse_checker (.*);
